/* src/lnl_pkg.sv */
// shared types and constants for the lif neuron layer
package lnl_pkg;

  localparam int NEURONS_DEF     = 64;
  localparam int PRE_NEURONS_DEF = 256;

  localparam int NEURON_W   = 6;
  localparam int PRESYN_W   = 8;
  localparam int VALUE_W    = 16;
  localparam int ACC_W      = 24;
  localparam int BETA_W     = 9;
  localparam int THR_W      = 23;
  localparam int NIN_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  localparam logic [BETA_W-1:0] BETA_RESET      = BETA_W'(230);
  localparam logic [THR_W-1:0]  THRESHOLD_RESET = THR_W'(256);
  localparam logic [NIN_W-1:0]  NEURONS_RESET   = NIN_W'(64);

  localparam logic [CFG_IDX_W-1:0] CFG_BETA      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_NEURONS   = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    ACT_LOAD_WEIGHT = 2'd0,
    ACT_LOAD_BIAS   = 2'd1,
    ACT_ACCUMULATE  = 2'd2,
    ACT_ACTIVATE    = 2'd3
  } action_t;

  typedef struct packed {
    action_t                    action;
    logic [NEURON_W-1:0]        neuron;
    logic [PRESYN_W-1:0]        presyn;
    logic signed [VALUE_W-1:0]  value;
  } in_item_t;

  typedef struct packed {
    logic [NEURON_W-1:0]      out_neuron;
    logic                     spike;
    logic signed [ACC_W-1:0]  potential;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_EXEC = 2'd1,
    ST_SUM  = 2'd2,
    ST_FIRE = 2'd3
  } state_t;

  typedef struct packed {
    logic capture;
    logic wr_weight;
    logic wr_bias;
    logic wr_acc;
    logic leak;
    logic sum;
    logic fire;
  } ctrl_cmd_t;

  typedef struct packed {
    action_t action;
    logic    ignore;
  } ctrl_stat_t;

endpackage

/* src/lnl_ctrl.sv */
// sequencing state machine for the lif neuron layer
module lnl_ctrl
  import lnl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (!stat.ignore && stat.action == ACT_ACTIVATE) state_next = ST_SUM;
        else state_next = ST_IDLE;
      end
      ST_SUM:  state_next = ST_FIRE;
      ST_FIRE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: cmd.capture = start;
      ST_EXEC: begin
        cmd.wr_weight = !stat.ignore && stat.action == ACT_LOAD_WEIGHT;
        cmd.wr_bias   = !stat.ignore && stat.action == ACT_LOAD_BIAS;
        cmd.wr_acc    = !stat.ignore && stat.action == ACT_ACCUMULATE;
        cmd.leak      = !stat.ignore && stat.action == ACT_ACTIVATE;
      end
      ST_SUM:  cmd.sum  = 1'b1;
      ST_FIRE: cmd.fire = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

/* src/lnl_datapath.sv */
// memories, configuration registers and arithmetic of the lif neuron layer
module lnl_datapath
  import lnl_pkg::*;
#(
  parameter int NEURONS     = NEURONS_DEF,
  parameter int PRE_NEURONS = PRE_NEURONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  in_item_t              item,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  ctrl_cmd_t             cmd,
  output ctrl_stat_t            stat,
  output logic                  done,
  output out_item_t             result
);

  localparam int NEUR_MAX = 2 ** NEURON_W;
  localparam int PRE_MAX  = 2 ** PRESYN_W;
  localparam int NEUR_EFF = (NEURONS < NEUR_MAX) ? NEURONS : NEUR_MAX;
  localparam int PRE_EFF  = (PRE_NEURONS < PRE_MAX) ? PRE_NEURONS : PRE_MAX;
  localparam int WDEPTH   = NEUR_EFF * PRE_EFF;
  localparam int WADDR_W  = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int NIDX_W   = (NEUR_EFF > 1) ? $clog2(NEUR_EFF) : 1;
  localparam int FULL_W   = NEURON_W + PRESYN_W;
  localparam int PROD_W   = ACC_W + BETA_W + 1;
  localparam int LEAK_W   = PROD_W - 8;
  localparam int TOT_W    = LEAK_W + 1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // configuration registers
  logic [BETA_W-1:0] beta;
  logic [THR_W-1:0]  fire_threshold;
  logic [NIN_W-1:0]  neurons_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      beta           <= BETA_RESET;
      fire_threshold <= THRESHOLD_RESET;
      neurons_in_use <= NEURONS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_BETA:      beta           <= cfg_data[BETA_W-1:0];
        CFG_THRESHOLD: fire_threshold <= cfg_data[THR_W-1:0];
        CFG_NEURONS:   neurons_in_use <= cfg_data[NIN_W-1:0];
        default: ;
      endcase
    end
  end

  // storage
  logic signed [VALUE_W-1:0] weight_mem [WDEPTH];
  logic signed [VALUE_W-1:0] bias_mem   [NEUR_EFF];
  logic signed [ACC_W-1:0]   acc_mem    [NEUR_EFF];
  logic signed [ACC_W-1:0]   memb_mem   [NEUR_EFF];
  logic [NEUR_EFF-1:0] bias_vld;
  logic [NEUR_EFF-1:0] acc_vld;
  logic [NEUR_EFF-1:0] memb_vld;

  // item capture and registered reads
  logic [FULL_W-1:0]  waddr_in;
  logic [NIDX_W-1:0]  nidx_in;
  logic               ignore_in;
  in_item_t           cur;
  logic [WADDR_W-1:0] waddr;
  logic [NIDX_W-1:0]  nidx;
  logic               ignore;
  logic signed [VALUE_W-1:0] weight_rd;
  logic signed [VALUE_W-1:0] bias_rd;
  logic signed [ACC_W-1:0]   acc_rd;
  logic signed [ACC_W-1:0]   memb_rd;
  logic bias_ok;
  logic acc_ok;
  logic memb_ok;

  assign waddr_in = FULL_W'(item.neuron) * FULL_W'(PRE_EFF) + FULL_W'(item.presyn);
  assign nidx_in  = item.neuron[NIDX_W-1:0];

  always_comb begin
    ignore_in = ({1'b0, item.neuron} >= neurons_in_use) ||
                (32'(item.neuron) >= NEURONS);
    if ((item.action == ACT_LOAD_WEIGHT || item.action == ACT_ACCUMULATE) &&
        32'(item.presyn) >= PRE_NEURONS) begin
      ignore_in = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur       <= item;
      waddr     <= waddr_in[WADDR_W-1:0];
      nidx      <= nidx_in;
      ignore    <= ignore_in;
      weight_rd <= weight_mem[waddr_in[WADDR_W-1:0]];
      bias_rd   <= bias_mem[nidx_in];
      acc_rd    <= acc_mem[nidx_in];
      memb_rd   <= memb_mem[nidx_in];
      bias_ok   <= bias_vld[nidx_in];
      acc_ok    <= acc_vld[nidx_in];
      memb_ok   <= memb_vld[nidx_in];
    end
  end

  assign stat.action = cur.action;
  assign stat.ignore = ignore;

  // bias, accumulator and membrane entries never written read as zero
  logic signed [VALUE_W-1:0] bias_cur;
  logic signed [ACC_W-1:0]   acc_cur;
  logic signed [ACC_W-1:0]   memb_cur;

  assign bias_cur = bias_ok ? bias_rd : '0;
  assign acc_cur  = acc_ok  ? acc_rd  : '0;
  assign memb_cur = memb_ok ? memb_rd : '0;

  // accumulate with saturation
  logic signed [ACC_W:0]   acc_wide;
  logic signed [ACC_W-1:0] acc_sum;

  assign acc_wide = (ACC_W+1)'(acc_cur) + (ACC_W+1)'(weight_rd);

  always_comb begin
    if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
      acc_sum = acc_wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sum = acc_wide[ACC_W-1:0];
    end
  end

  // leak multiply, floor shift by 8
  logic signed [PROD_W-1:0] prod;
  logic signed [LEAK_W-1:0] leak;

  assign prod = memb_cur * $signed({1'b0, beta});

  always_ff @(posedge clk) begin
    if (cmd.leak) leak <= prod[PROD_W-1:8];
  end

  // leak + accumulator + bias, saturated
  logic signed [TOT_W-1:0] tot;
  logic signed [ACC_W-1:0] pot_sat;

  assign tot = TOT_W'(leak) + TOT_W'(acc_cur) + TOT_W'(bias_cur);

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      if (tot[TOT_W-1:ACC_W-1] != {(TOT_W-ACC_W+1){tot[TOT_W-1]}}) begin
        pot_sat <= tot[TOT_W-1] ? ACC_MIN : ACC_MAX;
      end else begin
        pot_sat <= tot[ACC_W-1:0];
      end
    end
  end

  // threshold test and subtractive reset
  logic signed [ACC_W-1:0] thr_s;
  logic                    fired;
  logic signed [ACC_W-1:0] pot_new;

  assign thr_s   = $signed({1'b0, fire_threshold});
  assign fired   = pot_sat > thr_s;
  assign pot_new = fired ? pot_sat - thr_s : pot_sat;

  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      result.out_neuron <= cur.neuron;
      result.spike      <= fired;
      result.potential  <= pot_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.fire;
    end
  end

  // memory writes
  always_ff @(posedge clk) begin
    if (cmd.wr_weight) weight_mem[waddr] <= cur.value;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_bias) bias_mem[nidx] <= cur.value;
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_acc) begin
      acc_mem[nidx] <= acc_sum;
    end else if (cmd.fire) begin
      acc_mem[nidx] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fire) memb_mem[nidx] <= pot_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_vld <= '0;
      acc_vld  <= '0;
      memb_vld <= '0;
    end else begin
      if (cmd.wr_bias) bias_vld[nidx] <= 1'b1;
      if (cmd.wr_acc || cmd.fire) acc_vld[nidx] <= 1'b1;
      if (cmd.fire) memb_vld[nidx] <= 1'b1;
    end
  end

endmodule

/* src/lif_neuron_layer.sv */
// top level of the lif neuron layer
// An item is taken when start is high and busy is low. Loads, accumulations and
// ignored items pass through the accept state and the execute state; an
// activation passes through registered memory read, leak multiply, saturating
// sum, threshold and write-back. Its result word appears on result with done
// high for exactly one cycle, in the same cycle in which busy is low again, and
// cannot be held off; a new item may be started in that same cycle. Configuration
// writes are always ready and take effect on the next cycle.
module lif_neuron_layer
  import lnl_pkg::*;
#(
  parameter int NEURONS     = NEURONS_DEF,
  parameter int PRE_NEURONS = PRE_NEURONS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              item,
  output logic                  done,
  output out_item_t             result,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  assign cfg_ready = 1'b1;

  lnl_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lnl_datapath #(
    .NEURONS     (NEURONS),
    .PRE_NEURONS (PRE_NEURONS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .cfg_write (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .done      (done),
    .result    (result)
  );

endmodule
